/* hdl/tfr_pkg.sv */
// Shared types, constants and request structs of the telemetry frame receiver.
package tfr_pkg;

  // Byte store size and address width.
  localparam int unsigned BufferBytes = 64;
  localparam int unsigned AddrW       = $clog2(BufferBytes);

  // Frame codes.
  localparam logic [7:0] HdrByte   = 8'hAA;
  localparam logic [7:0] FuncLimit = 8'hF1;
  localparam logic [7:0] FuncAtt   = 8'h01;
  localparam logic [7:0] FuncImu   = 8'h02;
  localparam logic [7:0] FuncAckLo = 8'h10;
  localparam logic [7:0] FuncAckHi = 8'h15;

  // Offset of the first payload byte within a frame.
  localparam logic [8:0] PayloadOfs = 9'd4;

  // Number of values per result set, as last index.
  localparam logic [3:0] AttLastIdx = 4'd2;
  localparam logic [3:0] ImuLastIdx = 4'd8;
  localparam logic [3:0] AckLastIdx = 4'd0;

  // Result kinds as they appear on the output.
  typedef enum logic [1:0] {
    KIND_ATT = 2'd0,
    KIND_IMU = 2'd1,
    KIND_ACK = 2'd2
  } kind_e;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_FUNC = 3'd3,
    PH_LOAD = 3'd4,
    PH_SUM  = 3'd5
  } phase_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    CTL_RX  = 2'd0,
    CTL_RD  = 2'd1,
    CTL_OUT = 2'd2
  } ctl_e;

  // Write request into the byte store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // Dual read request from the byte store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr_hi;
    logic [AddrW-1:0] addr_lo;
  } store_rd_t;

endpackage

/* hdl/tfr_if.sv */
// Handshake channels of the telemetry frame receiver: received bytes and results.
interface tfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfr_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         func_code;
  logic [3:0]         axis_index;
  logic signed [15:0] value;
  logic [7:0]         ack_checksum;
  logic               last;

  modport source (output valid, output kind, output func_code, output axis_index,
                  output value, output ack_checksum, output last, input ready);
  modport sink   (input valid, input kind, input func_code, input axis_index,
                  input value, input ack_checksum, input last, output ready);
endinterface

/* hdl/tfr_store.sv */
// Frame byte store: one write port, two registered read ports, reads zero until written.
module tfr_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfr_pkg::store_wr_t  wr_i,
  input  tfr_pkg::store_rd_t  rd_i,
  output logic [7:0]          rd_hi_o,
  output logic [7:0]          rd_lo_o
);

  logic [7:0] mem [tfr_pkg::BufferBytes];
  logic [tfr_pkg::BufferBytes-1:0] written_q;
  logic [7:0] rd_hi_q;
  logic [7:0] rd_lo_q;

  // Per-entry written flags stand in for clearing the store at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.en) begin
      written_q[wr_i.addr] <= 1'b1;
    end
  end

  // Data array write.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered reads; an entry never written reads as zero.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_hi_q <= written_q[rd_i.addr_hi] ? mem[rd_i.addr_hi] : 8'h00;
      rd_lo_q <= written_q[rd_i.addr_lo] ? mem[rd_i.addr_lo] : 8'h00;
    end
  end

  assign rd_hi_o = rd_hi_q;
  assign rd_lo_o = rd_lo_q;

endmodule

/* hdl/telemetry_frame_receiver.sv */
// Top level of the telemetry frame receiver: byte parser, store sequencer and output register.
// Ready stays high except while results drain.
// After a good sum byte of an attitude, imu or ack frame the block reads two store bytes per
// value in CTL_RD and loads each result in CTL_OUT; ready rises after the last result.
// Results leave through an output register, so a held result stalls only the drain.
// Reset clears the parser and the store's written flags at once; no clearing sweep is needed.
module telemetry_frame_receiver (
  input  logic     clk_i,
  input  logic     rst_ni,
  tfr_rx_if.sink   rx_i,
  tfr_res_if.source res_o
);

  tfr_pkg::phase_e    phase_q, phase_d;
  tfr_pkg::ctl_e      ctl_q, ctl_d;
  tfr_pkg::kind_e     kind_q, kind_d;
  logic [7:0]         bytes_left_q, bytes_left_d;
  logic [7:0]         pcount_q, pcount_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         func_q, func_d;
  logic [3:0]         idx_q, idx_d;
  logic [3:0]         last_idx_q, last_idx_d;

  logic               out_valid_q, out_valid_d;
  tfr_pkg::kind_e     o_kind_q, o_kind_d;
  logic [7:0]         o_func_q, o_func_d;
  logic [3:0]         o_axis_q, o_axis_d;
  logic [15:0]        o_value_q, o_value_d;
  logic [7:0]         o_ack_q, o_ack_d;
  logic               o_last_q, o_last_d;

  tfr_pkg::store_wr_t wr;
  tfr_pkg::store_rd_t rd;
  logic [7:0]         rd_hi;
  logic [7:0]         rd_lo;

  logic               in_fire;
  logic               out_free;
  logic [7:0]         b;
  logic [8:0]         payload_addr;
  logic [4:0]         word_addr;

  // Bytes are taken only while no results are draining.
  assign rx_i.ready = (ctl_q == tfr_pkg::CTL_RX);

  assign in_fire  = rx_i.valid && rx_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign b        = rx_i.rx_byte;

  assign payload_addr = {1'b0, pcount_q} + tfr_pkg::PayloadOfs;
  assign word_addr    = {idx_q, 1'b0} + 5'(tfr_pkg::PayloadOfs);

  tfr_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (rd),
    .rd_hi_o (rd_hi),
    .rd_lo_o (rd_lo)
  );

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tfr_pkg::PH_IDLE;
      ctl_q        <= tfr_pkg::CTL_RX;
      bytes_left_q <= '0;
      pcount_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      ctl_q        <= ctl_d;
      bytes_left_q <= bytes_left_d;
      pcount_q     <= pcount_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    func_q     <= func_d;
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    o_kind_q   <= o_kind_d;
    o_func_q   <= o_func_d;
    o_axis_q   <= o_axis_d;
    o_value_q  <= o_value_d;
    o_ack_q    <= o_ack_d;
    o_last_q   <= o_last_d;
  end

  // Parser, store sequencer and output register loading.
  always_comb begin
    phase_d      = phase_q;
    ctl_d        = ctl_q;
    bytes_left_d = bytes_left_q;
    pcount_d     = pcount_q;
    sum_d        = sum_q;
    func_d       = func_q;
    kind_d       = kind_q;
    idx_d        = idx_q;
    last_idx_d   = last_idx_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    o_kind_d     = o_kind_q;
    o_func_d     = o_func_q;
    o_axis_d     = o_axis_q;
    o_value_d    = o_value_q;
    o_ack_d      = o_ack_q;
    o_last_d     = o_last_q;
    wr           = '0;
    rd           = '0;

    case (ctl_q)
      tfr_pkg::CTL_RX: begin
        if (in_fire) begin
          wr.data = b;
          sum_d   = (phase_q == tfr_pkg::PH_IDLE) ? b : 8'(sum_q + b);
          phase_d = tfr_pkg::PH_IDLE;
          case (phase_q)
            tfr_pkg::PH_IDLE: begin
              if (b == tfr_pkg::HdrByte) begin
                phase_d = tfr_pkg::PH_HDR1;
                wr.en   = 1'b1;
                wr.addr = tfr_pkg::AddrW'(0);
              end
            end
            tfr_pkg::PH_HDR1: begin
              if (b == tfr_pkg::HdrByte) begin
                phase_d = tfr_pkg::PH_HDR2;
                wr.en   = 1'b1;
                wr.addr = tfr_pkg::AddrW'(1);
              end
            end
            tfr_pkg::PH_HDR2: begin
              if (b != 8'h00 && b < tfr_pkg::FuncLimit) begin
                phase_d = tfr_pkg::PH_FUNC;
                func_d  = b;
                wr.en   = 1'b1;
                wr.addr = tfr_pkg::AddrW'(2);
              end
            end
            tfr_pkg::PH_FUNC: begin
              if ({1'b0, b} < 9'(tfr_pkg::BufferBytes - 4)) begin
                phase_d      = tfr_pkg::PH_LOAD;
                bytes_left_d = b;
                pcount_d     = '0;
                wr.en        = 1'b1;
                wr.addr      = tfr_pkg::AddrW'(3);
              end
            end
            tfr_pkg::PH_LOAD: begin
              if (bytes_left_q != 8'h00) begin
                phase_d      = (bytes_left_q == 8'h01) ? tfr_pkg::PH_SUM : tfr_pkg::PH_LOAD;
                bytes_left_d = bytes_left_q - 8'h01;
                pcount_d     = pcount_q + 8'h01;
                wr.en        = 1'b1;
                wr.addr      = tfr_pkg::AddrW'(payload_addr);
              end
            end
            tfr_pkg::PH_SUM: begin
              // The sum byte is stored too, and may be read back as value data.
              wr.en   = 1'b1;
              wr.addr = tfr_pkg::AddrW'(payload_addr);
              sum_d   = sum_q;
              idx_d   = '0;
              if (b == sum_q) begin
                if (func_q == tfr_pkg::FuncAtt) begin
                  kind_d     = tfr_pkg::KIND_ATT;
                  last_idx_d = tfr_pkg::AttLastIdx;
                  ctl_d      = tfr_pkg::CTL_RD;
                end else if (func_q == tfr_pkg::FuncImu) begin
                  kind_d     = tfr_pkg::KIND_IMU;
                  last_idx_d = tfr_pkg::ImuLastIdx;
                  ctl_d      = tfr_pkg::CTL_RD;
                end else if (func_q >= tfr_pkg::FuncAckLo && func_q <= tfr_pkg::FuncAckHi) begin
                  kind_d     = tfr_pkg::KIND_ACK;
                  last_idx_d = tfr_pkg::AckLastIdx;
                  ctl_d      = tfr_pkg::CTL_RD;
                end
              end
            end
            default: phase_d = tfr_pkg::PH_IDLE;
          endcase
        end
      end

      // Fetch both bytes of the current value.
      tfr_pkg::CTL_RD: begin
        rd.en      = 1'b1;
        rd.addr_hi = tfr_pkg::AddrW'(word_addr);
        rd.addr_lo = tfr_pkg::AddrW'(word_addr + 5'd1);
        ctl_d      = tfr_pkg::CTL_OUT;
      end

      // Hand the result to the output register once it is free.
      tfr_pkg::CTL_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = kind_q;
          o_func_d    = func_q;
          o_last_d    = (idx_q == last_idx_q);
          if (kind_q == tfr_pkg::KIND_ACK) begin
            o_axis_d  = '0;
            o_value_d = '0;
            o_ack_d   = sum_q;
          end else begin
            o_axis_d  = idx_q;
            o_value_d = {rd_hi, rd_lo};
            o_ack_d   = '0;
          end
          if (idx_q == last_idx_q) begin
            ctl_d = tfr_pkg::CTL_RX;
          end else begin
            idx_d = idx_q + 4'd1;
            ctl_d = tfr_pkg::CTL_RD;
          end
        end
      end

      default: ctl_d = tfr_pkg::CTL_RX;
    endcase
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = o_kind_q;
  assign res_o.func_code    = o_func_q;
  assign res_o.axis_index   = o_axis_q;
  assign res_o.value        = o_value_q;
  assign res_o.ack_checksum = o_ack_q;
  assign res_o.last         = o_last_q;

endmodule

/* hdl/tfr_checker.sv */
// Port-level checks of the telemetry frame receiver and their binding.
module tfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         kind_i,
  input logic [3:0]         axis_index_i,
  input logic signed [15:0] value_i,
  input logic [7:0]         ack_checksum_i,
  input logic               last_i
);

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i) && $stable(last_i))
    else $error("result changed while stalled");

  // An acknowledge is a single result with no value fields.
  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tfr_pkg::KIND_ACK |-> last_i && axis_index_i == 4'd0
      && value_i == 16'sd0)
    else $error("malformed acknowledge result");

  // Attitude sets close on the third axis.
  a_att_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tfr_pkg::KIND_ATT |-> ack_checksum_i == 8'h00
      && axis_index_i <= tfr_pkg::AttLastIdx && last_i == (axis_index_i == tfr_pkg::AttLastIdx))
    else $error("attitude result out of order");

  // Imu sets close on the ninth axis.
  a_imu_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tfr_pkg::KIND_IMU |-> ack_checksum_i == 8'h00
      && axis_index_i <= tfr_pkg::ImuLastIdx && last_i == (axis_index_i == tfr_pkg::ImuLastIdx))
    else $error("imu result out of order");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .axis_index_i   (res_o.axis_index),
  .value_i        (res_o.value),
  .ack_checksum_i (res_o.ack_checksum),
  .last_i         (res_o.last)
);
